// ===== rtl/core/lmfe_pkg.sv =====
// Shared types, codes and constants of the line marker filename extractor.
`default_nettype none
package lmfe_pkg;

	localparam int unsigned NAME_CAPACITY_DEF = 1024;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_LF_LO  = 8'h66;
	localparam logic [7:0] CH_LI     = 8'h69;
	localparam logic [7:0] CH_LL     = 8'h6C;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	typedef enum logic [3:0] {
		M_DISCOVER   = 4'd0,
		M_SKIP       = 4'd1,
		M_HASH_BLANK = 4'd2,
		M_L_I        = 4'd3,
		M_L_N        = 4'd4,
		M_L_E        = 4'd5,
		M_LINE_SEP   = 4'd6,
		M_LINE_BLANK = 4'd7,
		M_NUMBER     = 4'd8,
		M_NUM_BLANK  = 4'd9,
		M_NAME       = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_NEW     = 3'd1,
		KIND_SAME    = 3'd2,
		KIND_ABANDON = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUT,
		ACT_CLOSE,
		ACT_ABANDON,
		ACT_OPEN,
		ACT_ESC,
		ACT_DONE
	} act_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] name_char;
		logic [9:0] name_length;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic cmp_en;
		logic flush;
	} store_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/lmfe_name_store.sv =====
// Two-bank name memory with registered read and the delayed byte compare.
`default_nettype none
module lmfe_name_store #(
	parameter int unsigned NAME_CAPACITY = lmfe_pkg::NAME_CAPACITY_DEF,
	parameter int unsigned ADDR_W = $clog2(2 * NAME_CAPACITY)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  lmfe_pkg::store_ctrl_t    ctrl,
	input  wire  [ADDR_W-1:0]        waddr,
	input  wire  [ADDR_W-1:0]        raddr,
	input  wire  [7:0]               wdata,
	output logic                     hit
);
	import lmfe_pkg::*;

	localparam int unsigned DEPTH = 2 * NAME_CAPACITY;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_s2;
	logic [7:0] byte_s2;
	logic       cmp_s2;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[waddr] <= wdata;
		end
		rd_s2   <= mem[raddr];
		byte_s2 <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s2 <= 1'b0;
		end else begin
			cmp_s2 <= ctrl.cmp_en & ~ctrl.flush;
		end
	end

	assign hit = cmp_s2 & (rd_s2 != byte_s2);

endmodule
`default_nettype wire

// ===== rtl/core/lmfe_parser.sv =====
// Line marker parser, name length and recorded name bookkeeping.
`default_nettype none
module lmfe_parser #(
	parameter int unsigned NAME_CAPACITY = lmfe_pkg::NAME_CAPACITY_DEF,
	parameter int unsigned ADDR_W = $clog2(2 * NAME_CAPACITY)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      step,
	input  lmfe_pkg::in_item_t       item,
	input  wire                      hit,
	output lmfe_pkg::store_ctrl_t    ctrl,
	output logic [ADDR_W-1:0]        waddr,
	output logic [ADDR_W-1:0]        raddr,
	output logic [7:0]               wdata,
	output logic                     res_valid,
	output lmfe_pkg::out_item_t      res
);
	import lmfe_pkg::*;

	localparam int unsigned LEN_W = $clog2(NAME_CAPACITY + 1);

	mode_t            mode_q, mode_n;
	act_t             act;
	logic             esc_q;
	logic             rec_bank_q;
	logic [LEN_W-1:0] rec_len_q;
	logic             have_q;
	logic [LEN_W-1:0] len_q;
	logic             mismatch_q;
	logic [7:0]       c;
	logic [7:0]       put_b;
	logic             blank, digit, xdigit, eol;
	mode_t            fail_mode;
	logic             room, full, is_new;
	logic [LEN_W+9:0] len_ext;

	assign c         = item.char_in;
	assign blank     = (c == CH_SPACE) || (c == CH_TAB);
	assign digit     = (c >= CH_0) && (c <= CH_9);
	assign xdigit    = digit || ((c >= CH_LA) && (c <= CH_LF_LO)) ||
	                   ((c >= CH_UA) && (c <= CH_UF));
	assign eol       = (c == CH_CR) || (c == CH_LF);
	assign fail_mode = eol ? M_DISCOVER : M_SKIP;
	assign room      = len_q < LEN_W'(NAME_CAPACITY);
	assign full      = len_q >= LEN_W'(NAME_CAPACITY - 1);
	assign is_new    = !have_q || (len_q != rec_len_q) || mismatch_q || hit;
	assign len_ext   = {10'd0, len_q};

	always_comb begin
		act    = ACT_NONE;
		put_b  = c;
		mode_n = mode_q;
		if (item.end_of_input) begin
			act    = ACT_DONE;
			mode_n = M_DISCOVER;
		end else begin
			unique case (mode_q)
				M_SKIP: begin
					if (eol) mode_n = M_DISCOVER;
				end
				M_HASH_BLANK: begin
					if (!blank) begin
						if (c == CH_LL) mode_n = M_L_I;
						else if (digit) mode_n = M_NUMBER;
						else mode_n = fail_mode;
					end
				end
				M_L_I: mode_n = (c == CH_LI) ? M_L_N : M_SKIP;
				M_L_N: mode_n = (c == CH_LN) ? M_L_E : M_SKIP;
				M_L_E: mode_n = (c == CH_LE) ? M_LINE_SEP : M_SKIP;
				M_LINE_SEP: mode_n = blank ? M_LINE_BLANK : M_SKIP;
				M_LINE_BLANK: begin
					if (!blank) mode_n = digit ? M_NUMBER : fail_mode;
				end
				M_NUMBER: begin
					if (!xdigit) mode_n = blank ? M_NUM_BLANK : fail_mode;
				end
				M_NUM_BLANK: begin
					if (!blank) begin
						if (c == CH_QUOTE) begin
							mode_n = M_NAME;
							act    = ACT_OPEN;
						end else begin
							mode_n = fail_mode;
						end
					end
				end
				M_NAME: begin
					if (esc_q) begin
						act = room ? ACT_PUT : ACT_NONE;
						case (c)
							CH_BSLASH: put_b = CH_SLASH;
							CH_LT:     put_b = CH_TAB;
							CH_LR:     put_b = CH_CR;
							CH_LN:     put_b = CH_LF;
							CH_LB:     put_b = CH_BS;
							default:   act = ACT_NONE;
						endcase
					end else if (full) begin
						act    = ACT_ABANDON;
						mode_n = fail_mode;
					end else if (c == CH_BSLASH) begin
						act = ACT_ESC;
					end else if (c == CH_QUOTE) begin
						act    = ACT_CLOSE;
						mode_n = M_SKIP;
					end else begin
						act = room ? ACT_PUT : ACT_NONE;
					end
				end
				default: begin
					if (blank) mode_n = M_DISCOVER;
					else if (c == CH_HASH) mode_n = M_HASH_BLANK;
					else mode_n = fail_mode;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_DISCOVER;
			esc_q      <= 1'b0;
			rec_bank_q <= 1'b0;
			rec_len_q  <= '0;
			have_q     <= 1'b0;
			len_q      <= '0;
			mismatch_q <= 1'b0;
		end else begin
			if (step && (act == ACT_DONE || act == ACT_OPEN)) begin
				mismatch_q <= 1'b0;
			end else if (hit || (step && act == ACT_PUT && len_q >= rec_len_q)) begin
				mismatch_q <= 1'b1;
			end
			if (step) begin
				mode_q <= mode_n;
				unique case (act)
					ACT_DONE: begin
						esc_q      <= 1'b0;
						rec_bank_q <= 1'b0;
						rec_len_q  <= '0;
						have_q     <= 1'b0;
						len_q      <= '0;
					end
					ACT_OPEN: begin
						esc_q <= 1'b0;
						len_q <= '0;
					end
					ACT_ESC: esc_q <= 1'b1;
					ACT_PUT: begin
						esc_q <= 1'b0;
						len_q <= len_q + LEN_W'(1);
					end
					ACT_CLOSE: begin
						if (is_new) begin
							rec_bank_q <= ~rec_bank_q;
							rec_len_q  <= len_q;
							have_q     <= 1'b1;
						end
					end
					default: begin
						if (mode_q == M_NAME) esc_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_comb begin
		ctrl.wr_en  = step && (act == ACT_PUT);
		ctrl.cmp_en = step && (act == ACT_PUT) && (len_q < rec_len_q);
		ctrl.flush  = step && (act == ACT_DONE);
		wdata       = put_b;
		waddr       = rec_bank_q ? ADDR_W'(len_q) : ADDR_W'(NAME_CAPACITY) + ADDR_W'(len_q);
		raddr       = rec_bank_q ? ADDR_W'(NAME_CAPACITY) + ADDR_W'(len_q) : ADDR_W'(len_q);
		res_valid   = 1'b0;
		res         = '0;
		unique case (act)
			ACT_PUT: begin
				res_valid     = step;
				res.kind      = KIND_BYTE;
				res.name_char = put_b;
			end
			ACT_CLOSE: begin
				res_valid       = step;
				res.kind        = is_new ? KIND_NEW : KIND_SAME;
				res.name_length = len_ext[9:0];
			end
			ACT_ABANDON: begin
				res_valid = step;
				res.kind  = KIND_ABANDON;
			end
			ACT_DONE: begin
				res_valid = step;
				res.kind  = KIND_DONE;
			end
			default: res_valid = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/lmfe_out_buf.sv =====
// Result register with a skid stage.
`default_nettype none
module lmfe_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  lmfe_pkg::out_item_t  push_data,
	output logic                 push_ready,
	output logic                 result_valid,
	input  wire                  result_ready,
	output lmfe_pkg::out_item_t  result
);
	import lmfe_pkg::*;

	logic      main_v_q, skid_v_q;
	out_item_t main_q, skid_q;
	logic      take;

	assign take         = main_v_q & result_ready;
	assign push_ready   = ~skid_v_q;
	assign result_valid = main_v_q;
	assign result       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) skid_v_q <= 1'b1;
			else main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			if (main_v_q) skid_q <= push_data;
			else main_q <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/line_marker_filename_extractor.sv =====
// Top level of the line marker filename extractor.
// Each result is registered in the output buffer when the byte that causes it is accepted.
// Throughput: one byte per cycle while the skid stage is empty; the name store read for
// the compare is registered and is forwarded into the same-name decision.
// Reset: arst_n clears parse state, recorded name and result buffer; the name
// store is not cleared. end_of_input resets the parse state.
`default_nettype none
module line_marker_filename_extractor #(
	parameter int unsigned NAME_CAPACITY = lmfe_pkg::NAME_CAPACITY_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  lmfe_pkg::in_item_t   item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output lmfe_pkg::out_item_t  result
);
	import lmfe_pkg::*;

	localparam int unsigned ADDR_W = $clog2(2 * NAME_CAPACITY);

	logic              step;
	logic              hit;
	store_ctrl_t       ctrl;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata;
	logic              res_valid;
	out_item_t         res;

	assign step = item_valid & item_ready;

	lmfe_parser #(
		.NAME_CAPACITY(NAME_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item),
		.hit(hit),
		.ctrl(ctrl),
		.waddr(waddr),
		.raddr(raddr),
		.wdata(wdata),
		.res_valid(res_valid),
		.res(res)
	);

	lmfe_name_store #(
		.NAME_CAPACITY(NAME_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.waddr(waddr),
		.raddr(raddr),
		.wdata(wdata),
		.hit(hit)
	);

	lmfe_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res),
		.push_ready(item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
`default_nettype wire

// ===== dv/line_marker_filename_extractor_test.sv =====
// Self-checking testbench: streamed preprocessor bytes checked against a behavioral line marker parser.
`timescale 1ns / 1ps
module line_marker_filename_extractor_test;
	import lmfe_pkg::*;

	localparam int unsigned STORE_DEPTH = NAME_CAPACITY_DEF;

	typedef logic [7:0] text_t [$];

	typedef struct {
		in_item_t it;
		bit       wait_idle;
	} pending_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_item_t   result;

	pending_t    pending_bytes [$];
	out_item_t   expected_results [$];
	text_t       name_pool [4];
	bit          hold_next = 1'b0;
	bit          item_took = 1'b0;
	bit          calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int          bytes_total = -1;
	int          bytes_taken = 0;
	int          failures = 0;
	int          kind_count [0:7];

	// parser state
	mode_t       parse_state;
	bit          escape_open;
	bit          recorded_side;
	int unsigned recorded_len;
	bit          have_name;
	int unsigned name_len;
	bit          differs;
	logic [7:0]  name_bank [0:2*STORE_DEPTH-1];

	line_marker_filename_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_eol(logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

	function automatic void clear_parser();
		parse_state = M_DISCOVER;
		escape_open = 1'b0;
		recorded_side = 1'b0;
		recorded_len = 0;
		have_name = 1'b0;
		name_len = 0;
		differs = 1'b0;
	endfunction

	function automatic void fail_on(logic [7:0] c);
		parse_state = is_eol(c) ? M_DISCOVER : M_SKIP;
	endfunction

	function automatic void queue_result(kind_t k, logic [7:0] ch, logic [9:0] len);
		out_item_t r;
		r.kind = k;
		r.name_char = ch;
		r.name_length = len;
		expected_results.push_back(r);
	endfunction

	function automatic void store_name_byte(logic [7:0] b);
		int unsigned cur_base;
		int unsigned rec_base;
		cur_base = recorded_side ? 0 : STORE_DEPTH;
		rec_base = recorded_side ? STORE_DEPTH : 0;
		if (name_len >= STORE_DEPTH)
			return;
		name_bank[cur_base + name_len] = b;
		if (name_len >= recorded_len || name_bank[rec_base + name_len] != b)
			differs = 1'b1;
		name_len++;
		queue_result(KIND_BYTE, b, 10'd0);
	endfunction

	function automatic void predict_byte(in_item_t it);
		logic [7:0] c;
		logic [7:0] b;
		bit         take;
		bit         fresh;
		c = it.char_in;
		if (it.end_of_input) begin
			clear_parser();
			queue_result(KIND_DONE, 8'h00, 10'd0);
			return;
		end
		case (parse_state)
			M_SKIP: begin
				if (is_eol(c))
					parse_state = M_DISCOVER;
			end
			M_HASH_BLANK: begin
				if (!is_blank(c)) begin
					if (c == CH_LL)
						parse_state = M_L_I;
					else if (is_digit(c))
						parse_state = M_NUMBER;
					else
						fail_on(c);
				end
			end
			M_L_I: parse_state = (c == CH_LI) ? M_L_N : M_SKIP;
			M_L_N: parse_state = (c == CH_LN) ? M_L_E : M_SKIP;
			M_L_E: parse_state = (c == CH_LE) ? M_LINE_SEP : M_SKIP;
			M_LINE_SEP: parse_state = is_blank(c) ? M_LINE_BLANK : M_SKIP;
			M_LINE_BLANK: begin
				if (!is_blank(c)) begin
					if (is_digit(c))
						parse_state = M_NUMBER;
					else
						fail_on(c);
				end
			end
			M_NUMBER: begin
				if (!(is_digit(c) || (c >= CH_LA && c <= CH_LF_LO) || (c >= CH_UA && c <= CH_UF))) begin
					if (is_blank(c))
						parse_state = M_NUM_BLANK;
					else
						fail_on(c);
				end
			end
			M_NUM_BLANK: begin
				if (!is_blank(c)) begin
					if (c == CH_QUOTE) begin
						parse_state = M_NAME;
						name_len = 0;
						differs = 1'b0;
						escape_open = 1'b0;
					end else begin
						fail_on(c);
					end
				end
			end
			M_NAME: begin
				if (escape_open) begin
					escape_open = 1'b0;
					take = 1'b1;
					b = 8'h00;
					case (c)
						CH_BSLASH: b = CH_SLASH;
						CH_LT:     b = CH_TAB;
						CH_LR:     b = CH_CR;
						CH_LN:     b = CH_LF;
						CH_LB:     b = CH_BS;
						default:   take = 1'b0;
					endcase
					if (take)
						store_name_byte(b);
				end else if (name_len >= STORE_DEPTH - 1) begin
					fail_on(c);
					queue_result(KIND_ABANDON, 8'h00, 10'd0);
				end else if (c == CH_BSLASH) begin
					escape_open = 1'b1;
				end else if (c == CH_QUOTE) begin
					fresh = !have_name || name_len != recorded_len || differs;
					if (fresh) begin
						recorded_side = !recorded_side;
						recorded_len = name_len;
						have_name = 1'b1;
					end
					parse_state = M_SKIP;
					queue_result(fresh ? KIND_NEW : KIND_SAME, 8'h00, 10'(name_len));
				end else begin
					store_name_byte(c);
				end
			end
			default: begin
				if (is_blank(c))
					parse_state = M_DISCOVER;
				else if (c == CH_HASH)
					parse_state = M_HASH_BLANK;
				else
					fail_on(c);
			end
		endcase
	endfunction

	// request stream construction
	function automatic text_t as_text(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		return t;
	endfunction

	function automatic void put_char(logic [7:0] c);
		pending_t p;
		p.it.char_in = c;
		p.it.end_of_input = 1'b0;
		p.wait_idle = hold_next;
		hold_next = 1'b0;
		pending_bytes.push_back(p);
	endfunction

	function automatic void put_bytes(text_t t);
		foreach (t[i])
			put_char(t[i]);
	endfunction

	function automatic void put_text(string s);
		put_bytes(as_text(s));
	endfunction

	function automatic void put_end();
		pending_t p;
		p.it.char_in = 8'($urandom_range(0, 255));
		p.it.end_of_input = 1'b1;
		p.wait_idle = hold_next;
		hold_next = 1'b0;
		pending_bytes.push_back(p);
	endfunction

	function automatic void put_eol();
		case ($urandom_range(0, 2))
			0: put_char(CH_CR);
			1: put_char(CH_LF);
			default: begin
				put_char(CH_CR);
				put_char(CH_LF);
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic text_t fresh_name();
		text_t t;
		string alpha = "abcdefgxyz./_-";
		string esc = "\\trnb";
		int    r;
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				t.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
			end else if (r < 85) begin
				t.push_back(CH_BSLASH);
				t.push_back(esc[$urandom_range(0, 4)]);
			end else if (r < 92) begin
				t.push_back(CH_BSLASH);
				t.push_back(8'($urandom_range(0, 255)));
			end else begin
				t.push_back(plain_byte());
			end
		end
		return t;
	endfunction

	function automatic void put_marker(bit broken);
		text_t t;
		text_t nm;
		string hex = "0123456789abcdefABCDEF";
		int    cut;
		t.push_back(CH_HASH);
		repeat ($urandom_range(0, 2))
			t.push_back(pick_blank());
		if ($urandom_range(0, 2) == 0) begin
			t = {t, as_text("line")};
			repeat ($urandom_range(1, 2))
				t.push_back(pick_blank());
		end
		t.push_back(hex[$urandom_range(0, 9)]);
		repeat ($urandom_range(0, 3))
			t.push_back(hex[$urandom_range(0, hex.len() - 1)]);
		repeat ($urandom_range(1, 2))
			t.push_back(pick_blank());
		if ($urandom_range(0, 9) < 6) begin
			nm = name_pool[$urandom_range(0, 3)];
		end else begin
			nm = fresh_name();
			name_pool[$urandom_range(0, 3)] = nm;
		end
		t.push_back(CH_QUOTE);
		t = {t, nm};
		t.push_back(CH_QUOTE);
		if (broken) begin
			cut = $urandom_range(1, t.size() - 1);
			t = t[0:cut-1];
			case ($urandom_range(0, 3))
				0: t.push_back(CH_CR);
				1: t.push_back(CH_LF);
				default: t.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		repeat ($urandom_range(0, 3))
			t.push_back(8'($urandom_range(32, 126)));
		put_bytes(t);
		put_eol();
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic void log_failure(string what, out_item_t want, out_item_t got);
		failures++;
		if (failures <= 10)
			$display("[%0t] %s: expected kind %0d char %02h len %0d, got kind %0d char %02h len %0d",
				$realtime, what, want.kind, want.name_char, want.name_length,
				got.kind, got.name_char, got.name_length);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !item_took)) begin
			if (send_gap != 0) begin
				item_valid <= 1'b0;
				send_gap--;
			end else if (pending_bytes.size() != 0 &&
				(!pending_bytes[0].wait_idle || expected_results.size() == 0)) begin
				item <= pending_bytes[0].it;
				item_valid <= 1'b1;
				pending_bytes.delete(0);
				send_gap = pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			item_took = item_valid && item_ready;
			if (result_valid && result_ready) begin
				kind_count[result.kind]++;
				if (expected_results.size() == 0) begin
					log_failure("result with no request outstanding", '0, result);
				end else begin
					want = expected_results.pop_front();
					if (result.kind !== want.kind || result.name_char !== want.name_char ||
						result.name_length !== want.name_length)
						log_failure("result mismatch", want, result);
				end
			end
			if (item_took) begin
				bytes_taken++;
				predict_byte(item);
			end
			if ($urandom_range(0, 255) == 0)
				calm = ($urandom_range(0, 2) == 0);
		end else begin
			item_took = 1'b0;
		end
	end

	initial begin
		#25_000_000;
		$display("timeout with %0d requests pending and %0d results outstanding",
			bytes_total - bytes_taken, expected_results.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		text_t long_name;
		int    base;
		int    r;
		foreach (kind_count[k])
			kind_count[k] = 0;
		clear_parser();

		put_text("#1 \"a\"\n");
		put_text("# line\t2 \"a\"\r");
		put_text("#\t9fF \"\\\\\\t\\r\\n\\b\\\"\\q\"\n");
		put_text("#x\n#\r#lin\n# 5 \"z\"\n");
		put_text("#1 \"\"\n");
		put_end();
		put_text("#0 \"");
		put_char(8'h00);
		put_char(8'hFF);
		put_text("\"\n");

		// longest names: complete, repeat, escape at the limit, plain overflow
		repeat (STORE_DEPTH - 2)
			long_name.push_back(plain_byte());
		repeat (2) begin
			put_text("#1 \"");
			put_bytes(long_name);
			put_text("\"\n");
		end
		put_text("#1 \"");
		put_bytes(long_name);
		put_text("\\n\"\n");
		put_text("#1 \"");
		put_bytes(long_name);
		put_text("xy\"\n");

		hold_next = 1'b1;
		base = pending_bytes.size();
		while (pending_bytes.size() - base < 1850) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				hold_next = 1'b1;
			if (r < 58) begin
				put_marker(1'b0);
			end else if (r < 72) begin
				put_marker(1'b1);
			end else if (r < 82) begin
				repeat ($urandom_range(0, 12))
					put_char(8'($urandom_range(32, 126)));
				put_eol();
			end else if (r < 95) begin
				repeat ($urandom_range(3, 20))
					put_char(8'($urandom_range(0, 255)));
			end else begin
				put_end();
			end
		end
		put_end();
		bytes_total = pending_bytes.size();

		repeat (6) @(posedge clk);
		#5 arst_n = 1'b1;

		wait (bytes_taken == bytes_total);
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);

		$display("%0d requests checked: %0d name bytes, %0d new, %0d same, %0d abandoned, %0d done",
			bytes_taken, kind_count[KIND_BYTE], kind_count[KIND_NEW], kind_count[KIND_SAME],
			kind_count[KIND_ABANDON], kind_count[KIND_DONE]);
		$display("%0d failures found", failures);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
